[src/smd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg
// Shared widths, defaults, register codes and control structs of the
// sparsity map decoder.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int VALUE_W     = 16;
    localparam int INDEX_W     = 20;
    localparam int MAP_LEN_W   = 5;
    localparam int SIZE_W      = 21;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int DEF_MAX_IMAGE_SIZE = 1048576;
    localparam int DEF_MAP_WIDTH      = 16;

    localparam logic [MAP_LEN_W-1:0] MAP_LENGTH_RESET = 5'd16;
    localparam logic [SIZE_W-1:0]    IMAGE_SIZE_RESET = 21'd1048576;

    localparam logic REG_MAP_LENGTH = 1'b0;
    localparam logic REG_IMAGE_SIZE = 1'b1;

    typedef struct packed {
        logic accept;
        logic next_half;
        logic load_map;
        logic step_bit;
        logic zero_fill;
        logic flush;
    } smd_cmd_t;

    typedef struct packed {
        logic half_sel;
        logic half_valid;
        logic at_limit;
        logic pos_ge_len;
        logic map_zero;
        logic bit_set;
        logic zfill_end;
        logic can_emit;
        logic pend_valid;
        logic out_free;
    } smd_status_t;

endpackage

[src/smd_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_regs
// APB register file for map length and image size, with the effective
// (clamped) values used by the datapath.
// ----------------------------------------------------------------------------
module smd_regs #(
    parameter int MAX_IMAGE_SIZE = smd_pkg::DEF_MAX_IMAGE_SIZE,
    parameter int MAP_WIDTH      = smd_pkg::DEF_MAP_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [smd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [smd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [smd_pkg::MAP_LEN_W-1:0]     eff_len,
    output logic [smd_pkg::SIZE_W-1:0]        eff_size
);

    localparam logic [smd_pkg::MAP_LEN_W-1:0] MapW    = smd_pkg::MAP_LEN_W'(MAP_WIDTH);
    localparam logic [31:0]                   MaxSize = 32'(MAX_IMAGE_SIZE);

    logic [smd_pkg::MAP_LEN_W-1:0] map_length_reg, map_length_next;
    logic [smd_pkg::SIZE_W-1:0]    image_size_reg, image_size_next;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb begin
        map_length_next = map_length_reg;
        image_size_next = image_size_reg;
        if (wr_en) begin
            case (reg_sel)
                smd_pkg::REG_MAP_LENGTH: map_length_next = pwdata[smd_pkg::MAP_LEN_W-1:0];
                smd_pkg::REG_IMAGE_SIZE: image_size_next = pwdata[smd_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_length_reg <= smd_pkg::MAP_LENGTH_RESET;
            image_size_reg <= smd_pkg::IMAGE_SIZE_RESET;
        end else begin
            map_length_reg <= map_length_next;
            image_size_reg <= image_size_next;
        end
    end

    always_comb begin
        case (reg_sel)
            smd_pkg::REG_MAP_LENGTH:
                prdata = {{(smd_pkg::APB_DATA_W-smd_pkg::MAP_LEN_W){1'b0}}, map_length_reg};
            smd_pkg::REG_IMAGE_SIZE:
                prdata = {{(smd_pkg::APB_DATA_W-smd_pkg::SIZE_W){1'b0}}, image_size_reg};
            default: prdata = '0;
        endcase
    end

    always_comb begin
        if (map_length_reg == '0) begin
            eff_len = smd_pkg::MAP_LEN_W'(1);
        end else if (map_length_reg > MapW) begin
            eff_len = MapW;
        end else begin
            eff_len = map_length_reg;
        end
        if ({{(32-smd_pkg::SIZE_W){1'b0}}, image_size_reg} > MaxSize) begin
            eff_size = MaxSize[smd_pkg::SIZE_W-1:0];
        end else begin
            eff_size = image_size_reg;
        end
    end

endmodule

[src/smd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_ctrl
// Sequencer: takes a word, walks both halves one map position per cycle
// while output has room, then closes the word by releasing its final result.
// ----------------------------------------------------------------------------
module smd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  smd_pkg::smd_status_t status,
    output smd_pkg::smd_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_ZFILL = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!status.half_valid || status.at_limit) begin
                    if (status.half_sel) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.next_half = 1'b1;
                    end
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (status.pos_ge_len) begin
                    cmd.load_map = 1'b1;
                    if (status.map_zero) begin
                        state_next = ST_ZFILL;
                    end else if (status.half_sel) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.next_half = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end else if (status.can_emit) begin
                    cmd.step_bit = 1'b1;
                    if (status.bit_set) begin
                        if (status.half_sel) begin
                            state_next = ST_FLUSH;
                        end else begin
                            cmd.next_half = 1'b1;
                            state_next    = ST_CHECK;
                        end
                    end
                end
            end
            ST_ZFILL: begin
                if (status.can_emit) begin
                    cmd.zero_fill = 1'b1;
                    if (status.zfill_end) begin
                        if (status.half_sel) begin
                            state_next = ST_FLUSH;
                        end else begin
                            cmd.next_half = 1'b1;
                            state_next    = ST_CHECK;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/smd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_datapath
// Word latch, map and position registers, output counter, one pending
// result and the output register.
// ----------------------------------------------------------------------------
module smd_datapath #(
    parameter int MAP_WIDTH = smd_pkg::DEF_MAP_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [smd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [smd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser,
    input  logic [smd_pkg::MAP_LEN_W-1:0]      eff_len,
    input  logic [smd_pkg::SIZE_W-1:0]         eff_size,
    input  smd_pkg::smd_cmd_t                  cmd,
    output smd_pkg::smd_status_t               status
);

    localparam int IW = $clog2(MAP_WIDTH);
    localparam int VW = smd_pkg::VALUE_W;
    localparam int XW = smd_pkg::INDEX_W;
    localparam int LW = smd_pkg::MAP_LEN_W;
    localparam int SW = smd_pkg::SIZE_W;
    localparam logic [LW-1:0] MapW = LW'(MAP_WIDTH);

    logic [VW-1:0]        v0_reg, v1_reg;
    logic                 vld0_reg, vld1_reg;
    logic                 half_reg, half_next;
    logic [MAP_WIDTH-1:0] map_reg, map_next;
    logic [LW-1:0]        pos_reg, pos_next;
    logic [LW-1:0]        zcnt_reg, zcnt_next;
    logic [SW-1:0]        count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [VW-1:0]        pend_value_reg;
    logic [XW-1:0]        pend_index_reg;
    logic                 pend_done_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [VW-1:0]        out_value_reg;
    logic [XW-1:0]        out_index_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    logic [VW-1:0]        cur_v;
    logic                 cur_vld;
    logic                 bit_set;
    logic                 out_free;
    logic                 emit_req;
    logic                 emit_ok;
    logic                 push;
    logic [VW-1:0]        emit_value;
    logic [SW-1:0]        count_inc;

    assign cur_v     = half_reg ? v1_reg : v0_reg;
    assign cur_vld   = half_reg ? vld1_reg : vld0_reg;
    assign bit_set   = map_reg[pos_reg[IW-1:0]];
    assign out_free  = !out_valid_reg || m_tready;
    assign count_inc = count_reg + SW'(1);

    assign emit_req   = cmd.step_bit | cmd.zero_fill;
    assign emit_ok    = emit_req && (count_reg < eff_size);
    assign emit_value = (cmd.step_bit && bit_set) ? cur_v : '0;
    assign push       = (emit_ok && pend_valid_reg) || cmd.flush;

    always_comb begin
        status            = '0;
        status.half_sel   = half_reg;
        status.half_valid = cur_vld;
        status.at_limit   = (count_reg >= eff_size);
        status.pos_ge_len = (pos_reg >= eff_len);
        status.map_zero   = (cur_v[MAP_WIDTH-1:0] == '0);
        status.bit_set    = bit_set;
        status.zfill_end  = (zcnt_reg == (eff_len - LW'(1)));
        status.can_emit   = !pend_valid_reg || out_free;
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    always_comb begin
        half_next = half_reg;
        map_next  = map_reg;
        pos_next  = pos_reg;
        zcnt_next = zcnt_reg;
        if (cmd.accept) begin
            half_next = 1'b0;
        end
        if (cmd.next_half) begin
            half_next = 1'b1;
        end
        if (cmd.load_map) begin
            map_next  = cur_v[MAP_WIDTH-1:0];
            pos_next  = '0;
            zcnt_next = '0;
        end
        if (cmd.step_bit) begin
            pos_next = pos_reg + LW'(1);
            if (bit_set) begin
                map_next[pos_reg[IW-1:0]] = 1'b0;
            end
        end
        if (cmd.zero_fill) begin
            zcnt_next = zcnt_reg + LW'(1);
            if (status.zfill_end) begin
                pos_next = eff_len;
            end
        end
    end

    always_comb begin
        count_next      = emit_ok ? count_inc : count_reg;
        pend_valid_next = pend_valid_reg;
        if (emit_ok) begin
            pend_valid_next = 1'b1;
        end else if (cmd.flush) begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (push) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg       <= 1'b0;
            map_reg        <= '0;
            pos_reg        <= MapW;
            zcnt_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            half_reg       <= half_next;
            map_reg        <= map_next;
            pos_reg        <= pos_next;
            zcnt_reg       <= zcnt_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            v0_reg   <= s_tdata[15:0];
            vld0_reg <= s_tdata[16];
            v1_reg   <= s_tdata[32:17];
            vld1_reg <= s_tdata[33];
        end
        if (emit_ok) begin
            pend_value_reg <= emit_value;
            pend_index_reg <= count_reg[XW-1:0];
            pend_done_reg  <= (count_inc == eff_size);
        end
        if (push) begin
            out_value_reg <= pend_value_reg;
            out_index_reg <= pend_index_reg;
            out_done_reg  <= pend_done_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(smd_pkg::OUT_TDATA_W-XW-VW){1'b0}}, out_index_reg, out_value_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

[src/sparsity_map_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparsity_map_decoder_top
// Zero-skip sparsity map decompressor with stream input and output and an
// APB register port.
// ----------------------------------------------------------------------------
// One word at a time: a word is accepted, each half is checked, the map
// positions are walked (each gives one result, stalls when the output side
// backs up) with a map load whenever a group runs out, and finally the
// word's final result is released. The sequencer walks one map position per
// cycle while the output side has room. Each word's final result is held
// back until the word is done so that tlast can mark it. Once image_size
// results have been given, words are taken and give nothing.
// ----------------------------------------------------------------------------
module sparsity_map_decoder_top #(
    parameter int MAX_IMAGE_SIZE = smd_pkg::DEF_MAX_IMAGE_SIZE,
    parameter int MAP_WIDTH      = smd_pkg::DEF_MAP_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // lo_value[15:0], lo_valid[16], hi_value[32:17], hi_valid[33]
    input  logic [smd_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_value[15:0], pixel_index[35:16]
    output logic [smd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              m_tlast,
    // image_done[0]
    output logic                              m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [smd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [smd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [smd_pkg::MAP_LEN_W-1:0] eff_len;
    logic [smd_pkg::SIZE_W-1:0]    eff_size;
    smd_pkg::smd_cmd_t             cmd;
    smd_pkg::smd_status_t          status;

    smd_regs #(
        .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
        .MAP_WIDTH      (MAP_WIDTH)
    ) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_len  (eff_len),
        .eff_size (eff_size)
    );

    smd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smd_datapath #(
        .MAP_WIDTH (MAP_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .eff_len  (eff_len),
        .eff_size (eff_size),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

[src/smd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the sparsity map decoder, bound to the top level.
// ----------------------------------------------------------------------------
module smd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [smd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic                              m_tlast,
    input logic                              m_tuser
);

    logic [smd_pkg::INDEX_W-1:0] exp_index_reg;
    logic                        out_xfer;

    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_index_reg <= '0;
        end else if (out_xfer) begin
            exp_index_reg <= exp_index_reg + smd_pkg::INDEX_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_index_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> (m_tdata[35:16] == exp_index_reg))
        else $error("pixel index out of sequence");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken before the first was processed");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image done result not marked last of word");

endmodule

bind sparsity_map_decoder_top smd_checker u_smd_checker (.*);

[sim/sparsity_map_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparsity_map_decoder_top_tb
// Self-checking bench for the sparsity map decoder. Words go in on the input
// stream, and every decoded pixel is compared against a software decoder that
// tracks the map, the group position and the image count. Directed words cover
// the reset defaults, extreme values, partial words, map lengths and size
// limits. Random map groups follow, with noise halves and broken groups,
// random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module sparsity_map_decoder_top_tb;

    localparam int VALUE_W     = smd_pkg::VALUE_W;
    localparam int INDEX_W     = smd_pkg::INDEX_W;
    localparam int MAP_LEN_W   = smd_pkg::MAP_LEN_W;
    localparam int SIZE_W      = smd_pkg::SIZE_W;
    localparam int IN_TDATA_W  = smd_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = smd_pkg::OUT_TDATA_W;
    localparam int APB_ADDR_W  = smd_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = smd_pkg::APB_DATA_W;
    localparam logic REG_MAP_LENGTH = smd_pkg::REG_MAP_LENGTH;
    localparam logic REG_IMAGE_SIZE = smd_pkg::REG_IMAGE_SIZE;

    localparam int MAP_BITS       = smd_pkg::DEF_MAP_WIDTH;
    localparam int IMAGE_MAX      = smd_pkg::DEF_MAX_IMAGE_SIZE;
    localparam int IDLE_WAIT      = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 270;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               done;
    } pixel_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    m_tlast;
    logic                    m_tuser;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // decoder state mirrored by the bench
    logic [MAP_LEN_W-1:0]    cfg_map_length = smd_pkg::MAP_LENGTH_RESET;
    logic [SIZE_W-1:0]       cfg_image_size = smd_pkg::IMAGE_SIZE_RESET;
    logic [MAP_BITS-1:0]     map_bits = '0;
    int                      map_pos = MAP_BITS;
    int                      pixels_out = 0;

    pixel_t                  pixel_q[$];
    pixel_t                  word_pixels[$];
    pixel_t                  want;
    logic [VALUE_W-1:0]      halves_q[$];

    int errors       = 0;
    int pixels_seen  = 0;
    int words_live   = 0;
    int words_sent   = 0;
    int stuck_cycles = 0;
    int hold_cycles  = 0;
    int rx_stall     = 0;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    sparsity_map_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic void log_error(string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function automatic int group_len();
        int len;
        len = cfg_map_length;
        if (len == 0) len = 1;
        if (len > MAP_BITS) len = MAP_BITS;
        return len;
    endfunction

    function automatic int image_limit();
        int lim;
        lim = cfg_image_size;
        if (lim > IMAGE_MAX) lim = IMAGE_MAX;
        return lim;
    endfunction

    function automatic void emit_pixel(logic [VALUE_W-1:0] v);
        pixel_t p;
        if (pixels_out >= image_limit()) return;
        p.value = v;
        p.index = pixels_out[INDEX_W-1:0];
        p.last  = 1'b0;
        pixels_out++;
        p.done  = (pixels_out == image_limit());
        word_pixels.push_back(p);
    endfunction

    function automatic void load_group(logic [VALUE_W-1:0] v, int len);
        int i;
        map_bits = v;
        map_pos  = 0;
        if (v == '0) begin
            for (i = 0; i < len; i++) emit_pixel('0);
            map_pos = len;
        end
    endfunction

    function automatic void take_half(logic [VALUE_W-1:0] v);
        int len;
        int idx;
        len = group_len();
        if (pixels_out >= image_limit()) return;
        if (map_pos >= len) begin
            load_group(v, len);
            return;
        end
        for (idx = map_pos; idx < len; idx++) begin
            map_pos = idx + 1;
            if (map_bits[idx]) begin
                map_bits[idx] = 1'b0;
                emit_pixel(v);
                return;
            end
            emit_pixel('0);
            if (map_pos == len) begin
                load_group(v, len);
                return;
            end
        end
    endfunction

    function automatic void decode_word(logic [VALUE_W-1:0] fv, logic fok,
                                        logic [VALUE_W-1:0] sv, logic sok);
        word_pixels.delete();
        if (fok) take_half(fv);
        if (sok) take_half(sv);
        if (word_pixels.size() > 0) word_pixels[word_pixels.size()-1].last = 1'b1;
        foreach (word_pixels[i]) pixel_q.push_back(word_pixels[i]);
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void plan_group(int len);
        logic [MAP_BITS-1:0] low_mask;
        logic [MAP_BITS-1:0] grp_map;
        int count;
        int i;
        low_mask = 16'((32'h1 << len) - 1);
        case ($urandom_range(0, 9))
            0: grp_map = '0;
            1: grp_map = 16'($urandom) & ~low_mask;
            2: grp_map = '1;
            3: grp_map = 16'(32'h1 << $urandom_range(0, MAP_BITS - 1));
            default: grp_map = 16'($urandom);
        endcase
        count = $countones(grp_map & low_mask);
        if ($urandom_range(0, 7) == 0) count = $urandom_range(0, count + 2);
        halves_q.push_back(grp_map);
        for (i = 0; i < count; i++) halves_q.push_back(pick_value());
    endfunction

    // entered and left at a falling edge; tvalid stays high for a back-to-back word
    task automatic send_word(input logic [VALUE_W-1:0] fv, input logic fok,
                             input logic [VALUE_W-1:0] sv, input logic sok);
        int gap;
        gap = tx_idle_en ? pause_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'b0, sok, sv, fok, fv};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if ((fok || sok) && pixels_out < image_limit()) words_live++;
        decode_word(fv, fok, sv, sok);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pixel_q.size() > 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_MAP_LENGTH) cfg_map_length = value[MAP_LEN_W-1:0];
        else cfg_image_size = value[SIZE_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_stream(input int n_words);
        logic [VALUE_W-1:0] h[2];
        logic               ok[2];
        int w;
        int k;
        halves_q.delete();
        for (w = 0; w < n_words; w++) begin
            for (k = 0; k < 2; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    ok[k] = 1'b0;
                    h[k]  = 16'($urandom);
                end else begin
                    if (halves_q.size() == 0) plan_group(group_len());
                    ok[k] = 1'b1;
                    h[k]  = halves_q.pop_front();
                end
            end
            send_word(h[0], ok[0], h[1], ok[1]);
        end
    endtask

    task automatic test_defaults();
        send_word(16'h0000, 1'b1, 16'h8001, 1'b1);
        send_word(16'h8000, 1'b1, 16'h7FFF, 1'b1);
        send_word(16'($urandom), 1'b0, 16'($urandom), 1'b0);
        send_word(16'($urandom), 1'b0, 16'hFFFF, 1'b1);
        send_word(16'h7FFF, 1'b1, 16'h8000, 1'b1);
        send_word(16'h1234, 1'b1, 16'($urandom), 1'b0);
    endtask

    task automatic test_map_lengths();
        drain();
        write_reg(REG_MAP_LENGTH, 32'd4);
        send_word(16'h4444, 1'b1, 16'h00F0, 1'b1);
        send_word(16'h0003, 1'b1, 16'hAAAA, 1'b1);
        send_word(16'h5555, 1'b1, 16'h0000, 1'b1);
        drain();
        write_reg(REG_MAP_LENGTH, 32'd0);
        send_word(16'h0001, 1'b1, 16'h0F0F, 1'b1);
        send_word(16'h0000, 1'b1, 16'h0000, 1'b1);
        drain();
        write_reg(REG_MAP_LENGTH, 32'd31);
        send_word(16'hFFFF, 1'b1, 16'h0101, 1'b1);
        drain();
        write_reg(REG_MAP_LENGTH, 32'd1);
        send_word(16'h0000, 1'b1, 16'h0002, 1'b1);
        send_word(16'h1111, 1'b1, 16'($urandom), 1'b0);
        drain();
        write_reg(REG_MAP_LENGTH, 32'd17);
        send_word(16'h00FF, 1'b1, 16'h0000, 1'b1);
        drain();
        write_reg(REG_MAP_LENGTH, 32'd16);
    endtask

    task automatic test_image_limits();
        drain();
        write_reg(REG_IMAGE_SIZE, pixels_out + 5);
        send_word(16'h0000, 1'b1, 16'h0000, 1'b1);
        send_word(16'h1234, 1'b1, 16'h5678, 1'b1);
        drain();
        write_reg(REG_IMAGE_SIZE, 32'd1);
        send_word(16'h0000, 1'b1, 16'h0000, 1'b1);
        drain();
        write_reg(REG_IMAGE_SIZE, 32'd0);
        send_word(16'h0000, 1'b1, 16'hFFFF, 1'b1);
        drain();
        write_reg(REG_IMAGE_SIZE, 32'h001F_FFFF);
        send_word(16'h0000, 1'b1, 16'($urandom), 1'b0);
        drain();
        write_reg(REG_IMAGE_SIZE, IMAGE_MAX);
        send_word(16'h0000, 1'b1, 16'h0000, 1'b1);
    endtask

    task automatic test_backpressure();
        int i;
        drain();
        tx_idle_en  = 1'b0;
        hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 8; i++) send_word(16'h0000, 1'b1, 16'h0000, 1'b1);
        send_stream(12);
        drain();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random();
        int start;
        bit limited;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            drain();
            case ($urandom_range(0, 9))
                0: write_reg(REG_MAP_LENGTH, 32'd0);
                1: write_reg(REG_MAP_LENGTH, $urandom_range(17, 31));
                2: write_reg(REG_MAP_LENGTH, 32'd16);
                default: write_reg(REG_MAP_LENGTH, $urandom_range(1, 16));
            endcase
            limited = ($urandom_range(0, 3) == 0);
            if (limited) write_reg(REG_IMAGE_SIZE, pixels_out + $urandom_range(1, 80));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            send_stream($urandom_range(15, 40));
            if (limited) begin
                drain();
                if ($urandom_range(0, 1) == 0) write_reg(REG_IMAGE_SIZE, IMAGE_MAX);
                else write_reg(REG_IMAGE_SIZE, 32'h001F_FFFF);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_en) rx_stall = pause_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                log_error($sformatf("unexpected pixel value %h index %0d",
                                    m_tdata[15:0], m_tdata[35:16]));
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[15:0] !== want.value || m_tdata[35:16] !== want.index ||
                    m_tlast !== want.last || m_tuser !== want.done) begin
                    log_error($sformatf({"pixel %0d: expected value %h index %0d last %b ",
                                         "done %b, got value %h index %0d last %b done %b"},
                                        pixels_seen, want.value, want.index, want.last,
                                        want.done, m_tdata[15:0], m_tdata[35:16], m_tlast,
                                        m_tuser));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_defaults();
        test_map_lengths();
        test_image_limits();
        test_backpressure();
        test_random();
        drain();

        if (pixel_q.size() != 0) log_error($sformatf("%0d pixels never arrived", pixel_q.size()));
        $display("covered %0d words (%0d live) and %0d pixels over map lengths 0..31,",
                 words_sent, words_live, pixels_seen);
        $display("image size limits 0..2097151, noise halves and a long output stall");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d errors", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
